// ===== sv/min_heap_priority_queue_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Min-heap priority queue assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MIN_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Property holds at every clock edge outside reset.
`define MHPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition never holds at a clock edge outside reset.
`define MHPQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== sv/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Min-heap priority queue package
// Sizes, item types, status and operation codes, memory request bundle.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned TAG_W = 32;
  localparam int unsigned ENTRY_W = KEY_W + TAG_W;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } mhpq_status_e;

  typedef struct packed {
    logic              operation;
    logic signed [KEY_W-1:0] priority_req;
    logic [TAG_W-1:0]  payload;
  } mhpq_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [TAG_W-1:0] min_payload;
    logic [CNT_W-1:0] occupancy;
    logic             heap_empty;
  } mhpq_out_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } mhpq_entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    mhpq_entry_t      wdata;
    logic [IDX_W-1:0] raddr_a;
    logic [IDX_W-1:0] raddr_b;
  } mhpq_mem_req_t;

endpackage

// ===== sv/mhpq_ram.sv =====
// ----------------------------------------------------------------------------
// Min-heap priority queue entry RAM
// One write port, two read ports, registered read data, no reset on contents.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned DATA_W = 64,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ===== sv/mhpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Min-heap priority queue sequencer
// Walks sift-up and sift-down one heap level per cycle against the entry RAM.
// ----------------------------------------------------------------------------
`include "min_heap_priority_queue_unit_defines.svh"

module mhpq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  mhpq_pkg::mhpq_in_t    in_data_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output mhpq_pkg::mhpq_out_t   res_o,
  output mhpq_pkg::mhpq_mem_req_t mem_o,
  input  mhpq_pkg::mhpq_entry_t rdata_a_i,
  input  mhpq_pkg::mhpq_entry_t rdata_b_i
);
  import mhpq_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_CMP  = 3'd1;
  localparam logic [2:0] S_DN_LOAD = 3'd2;
  localparam logic [2:0] S_DN_CMP  = 3'd3;
  localparam logic [2:0] S_PLACE   = 3'd4;
  localparam logic [2:0] S_FINISH  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] hole_q, hole_d;
  mhpq_entry_t      x_q, x_d;
  mhpq_status_e     status_q, status_d;
  logic [TAG_W-1:0] res_tag_q, res_tag_d;

  logic             in_fire;
  logic [IDX_W-1:0] parent_idx;
  logic [IDX_W:0]   c_cur, r_cur, nxt_c, nxt_r;
  logic             right_ok, pick_b;
  mhpq_entry_t      pick;
  logic [IDX_W-1:0] cidx;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    parent_idx = (hole_q - IDX_W'(1)) >> 1;
    c_cur      = {hole_q, 1'b1};
    r_cur      = c_cur + (IDX_W+1)'(1);
    right_ok   = r_cur < cnt_q;
    pick_b     = right_ok && ($signed(rdata_b_i.key) < $signed(rdata_a_i.key));
    pick       = pick_b ? rdata_b_i : rdata_a_i;
    cidx       = pick_b ? r_cur[IDX_W-1:0] : c_cur[IDX_W-1:0];
    nxt_c      = {cidx, 1'b1};
    nxt_r      = nxt_c + (IDX_W+1)'(1);
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    hole_d    = hole_q;
    x_d       = x_q;
    status_d  = status_q;
    res_tag_d = res_tag_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_o.we      = 1'b0;
    mem_o.waddr   = hole_q;
    mem_o.wdata   = x_q;
    mem_o.raddr_a = '0;
    mem_o.raddr_b = '0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          x_d.key   = in_data_i.priority_req;
          x_d.tag   = in_data_i.payload;
          res_tag_d = '0;
          status_d  = ST_DONE;
          if (in_data_i.operation == OP_INSERT) begin
            if (cnt_q == CNT_W'(DEPTH)) begin
              status_d = ST_FULL;
              state_d  = S_FINISH;
            end else begin
              cnt_d  = cnt_q + CNT_W'(1);
              hole_d = cnt_q[IDX_W-1:0];
              if (cnt_q == '0) begin
                mem_o.we    = 1'b1;
                mem_o.waddr = '0;
                mem_o.wdata = x_d;
                state_d     = S_FINISH;
              end else begin
                mem_o.raddr_a = (cnt_q[IDX_W-1:0] - IDX_W'(1)) >> 1;
                state_d       = S_UP_CMP;
              end
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_FINISH;
            end else begin
              // fetch root and last entry together
              cnt_d         = cnt_q - CNT_W'(1);
              mem_o.raddr_a = '0;
              mem_o.raddr_b = cnt_d[IDX_W-1:0];
              state_d       = S_DN_LOAD;
            end
          end
        end
      end

      S_UP_CMP: begin
        mem_o.we = 1'b1;
        if ($signed(x_q.key) < $signed(rdata_a_i.key)) begin
          // move parent down into the hole
          mem_o.wdata = rdata_a_i;
          hole_d      = parent_idx;
          if (parent_idx == '0) begin
            state_d = S_PLACE;
          end else begin
            mem_o.raddr_a = (parent_idx - IDX_W'(1)) >> 1;
          end
        end else begin
          state_d = S_FINISH;
        end
      end

      S_DN_LOAD: begin
        res_tag_d = rdata_a_i.tag;
        x_d       = rdata_b_i;
        hole_d    = '0;
        if (cnt_q == '0) begin
          state_d = S_FINISH;
        end else if (cnt_q == CNT_W'(1)) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = '0;
          mem_o.wdata = rdata_b_i;
          state_d     = S_FINISH;
        end else begin
          mem_o.raddr_a = IDX_W'(1);
          mem_o.raddr_b = IDX_W'(2);
          state_d       = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        mem_o.we = 1'b1;
        if ($signed(x_q.key) < $signed(pick.key)) begin
          state_d = S_FINISH;
        end else begin
          // pull the chosen child up into the hole
          mem_o.wdata = pick;
          hole_d      = cidx;
          if (nxt_c >= cnt_q) begin
            state_d = S_PLACE;
          end else begin
            mem_o.raddr_a = nxt_c[IDX_W-1:0];
            mem_o.raddr_b = nxt_r[IDX_W-1:0];
          end
        end
      end

      S_PLACE: begin
        mem_o.we = 1'b1;
        state_d  = S_FINISH;
      end

      S_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.status      = status_q;
  assign res_o.min_payload = res_tag_q;
  assign res_o.occupancy   = cnt_q;
  assign res_o.heap_empty  = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hole_q    <= hole_d;
    x_q       <= x_d;
    status_q  <= status_d;
    res_tag_q <= res_tag_d;
  end

  `MHPQ_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "entry count above depth")
  `MHPQ_ASSERT(a_cnt_only_on_accept, !in_fire |=> $stable(cnt_q), "count moved without an item")
  `MHPQ_ASSERT(a_empty_extract, (in_fire && in_data_i.operation == OP_EXTRACT && cnt_q == '0) |=> (state_q == S_FINISH && status_q == ST_EMPTY), "empty extract not reported")
  `MHPQ_ASSERT_NEVER(a_no_write_in_finish, state_q == S_FINISH && mem_o.we, "write while result pending")
  `MHPQ_ASSERT_NEVER(a_rw_overlap, mem_o.we && (state_q == S_UP_CMP || state_q == S_DN_CMP) && state_d == state_q && (mem_o.waddr == mem_o.raddr_a), "read and write hit the same entry")

endmodule

// ===== sv/min_heap_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Min-heap priority queue unit
// Binary min-heap of signed keys with payload tags, kept in one entry RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one item: insert a
//   key and payload, or extract the minimum. Each item yields exactly one
//   result on the output channel (out_valid_o/out_ready_i/out_data_o) with a
//   status, the extracted payload, the occupancy and an empty flag.
//   An insert into a full heap is dropped with status full; an extract from
//   an empty heap returns status empty and a zero payload.
//   The heap walk advances one level per cycle, set by the entry RAM's
//   single write port and its registered read data.
//   One item is in work at a time; the next item is taken as soon as the
//   previous result has moved into the output register, even if the
//   receiver has not taken it yet. A stalled receiver holds the result and,
//   once a second result is ready, holds the sequencer too.
//   Reset empties the heap at once; no clearing pass runs over the RAM.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mhpq_pkg::mhpq_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mhpq_pkg::mhpq_out_t out_data_o
);
  import mhpq_pkg::*;

  mhpq_mem_req_t mem_req;
  mhpq_entry_t   rdata_a, rdata_b;
  logic          res_valid, res_ready;
  mhpq_out_t     res;
  logic          out_valid_q, out_valid_d;
  mhpq_out_t     out_data_q;

  mhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_o       (mem_req),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b)
  );

  mhpq_ram #(
    .DEPTH  (DEPTH),
    .DATA_W (ENTRY_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (mem_req.we),
    .waddr_i   (mem_req.waddr),
    .wdata_i   (mem_req.wdata),
    .raddr_a_i (mem_req.raddr_a),
    .raddr_b_i (mem_req.raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // output register: refill when empty or draining
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Min-heap priority queue testbench
// Drives insert and extract items through the valid/ready channels, predicts
// every result with a software heap, and checks each result field by field.
// Covers empty and full heaps, equal keys, key extremes and random traffic.
// ----------------------------------------------------------------------------
module testbench;
  import mhpq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_CYCLES = 20;

  // Software heap that tracks the block and holds the results still owed.
  class heap_scoreboard;
    logic signed [KEY_W-1:0] key_mem [DEPTH];
    logic [TAG_W-1:0]        tag_mem [DEPTH];
    int unsigned             fill;
    mhpq_out_t               owed_q[$];
    int unsigned             errors;
    int unsigned             n_insert;
    int unsigned             n_dropped;
    int unsigned             n_extract;
    int unsigned             n_on_empty;
    int unsigned             n_checked;

    function new();
      fill = 0;
      errors = 0;
      n_insert = 0;
      n_dropped = 0;
      n_extract = 0;
      n_on_empty = 0;
      n_checked = 0;
    endfunction

    function void swap_entries(int unsigned a, int unsigned b);
      logic signed [KEY_W-1:0] k;
      logic [TAG_W-1:0]        t;
      k = key_mem[a];
      t = tag_mem[a];
      key_mem[a] = key_mem[b];
      tag_mem[a] = tag_mem[b];
      key_mem[b] = k;
      tag_mem[b] = t;
    endfunction

    // Apply an accepted item to the heap and queue the result it owes.
    function void note_input(mhpq_in_t item);
      mhpq_out_t   res;
      int unsigned i;
      int unsigned c;
      int unsigned last;
      res = '0;
      res.status = ST_DONE;
      if (item.operation == OP_INSERT) begin
        n_insert++;
        if (fill >= DEPTH) begin
          res.status = ST_FULL;
          n_dropped++;
        end else begin
          i = fill;
          key_mem[i] = item.priority_req;
          tag_mem[i] = item.payload;
          while (i > 0 && key_mem[i] < key_mem[(i - 1) / 2]) begin
            swap_entries(i, (i - 1) / 2);
            i = (i - 1) / 2;
          end
          fill++;
        end
      end else begin
        n_extract++;
        if (fill == 0) begin
          res.status = ST_EMPTY;
          n_on_empty++;
        end else begin
          last = fill - 1;
          res.min_payload = tag_mem[0];
          key_mem[0] = key_mem[last];
          tag_mem[0] = tag_mem[last];
          fill = last;
          i = 0;
          // Equal keys swap; only a strictly smaller parent stops the walk.
          while (2 * i + 1 < last) begin
            c = 2 * i + 1;
            if (c + 1 < last && key_mem[c + 1] < key_mem[c]) c = c + 1;
            if (key_mem[i] < key_mem[c]) break;
            swap_entries(i, c);
            i = c;
          end
        end
      end
      res.occupancy = fill[CNT_W-1:0];
      res.heap_empty = (fill == 0);
      owed_q.push_back(res);
    endfunction

    function void check_result(mhpq_out_t got);
      mhpq_out_t exp;
      if (owed_q.size() == 0) begin
        $error("result with nothing owed: %p", got);
        errors++;
        return;
      end
      exp = owed_q.pop_front();
      n_checked++;
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.min_payload !== exp.min_payload) begin
        $error("min_payload: expected %h, got %h", exp.min_payload, got.min_payload);
        errors++;
      end
      if (got.occupancy !== exp.occupancy) begin
        $error("occupancy: expected %0d, got %0d", exp.occupancy, got.occupancy);
        errors++;
      end
      if (got.heap_empty !== exp.heap_empty) begin
        $error("heap_empty: expected %0d, got %0d", exp.heap_empty, got.heap_empty);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  mhpq_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  mhpq_out_t out_data_o;

  heap_scoreboard sb;
  int unsigned    cycles;
  int unsigned    n_sent;
  int unsigned    n_taken;
  bit             in_quiet;
  bit             out_quiet;

  min_heap_priority_queue_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results owed", cycles, sb.owed_q.size());
      $display("** min_heap_priority_queue_unit: FAILED **");
      $finish;
    end
  end

  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return int'($urandom_range(0, 8)) - 4;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return int'($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  function automatic mhpq_in_t make_insert(logic signed [KEY_W-1:0] key,
                                           logic [TAG_W-1:0] tag);
    mhpq_in_t item;
    item.operation = OP_INSERT;
    item.priority_req = key;
    item.payload = tag;
    return item;
  endfunction

  // Unused fields of an extract carry noise; the block must ignore them.
  function automatic mhpq_in_t make_extract();
    mhpq_in_t item;
    item.operation = OP_EXTRACT;
    item.priority_req = $urandom;
    item.payload = $urandom;
    return item;
  endfunction

  task automatic send_item(input mhpq_in_t item);
    int unsigned gap;
    gap = in_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(item);
    n_sent++;
    if (n_sent % 64 == 0) in_quiet = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_random_item(input int unsigned insert_pct);
    if ($urandom_range(0, 99) < insert_pct) send_item(make_insert(pick_key(), $urandom));
    else send_item(make_extract());
  endtask

  task automatic run_mixed(input int unsigned count, input int unsigned insert_pct);
    repeat (count) send_random_item(insert_pct);
  endtask

  // Receiver: draw a stall per result, then take the next one.
  initial begin
    int unsigned stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = out_quiet ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(out_data_o);
      n_taken++;
      if (n_taken % 64 == 0) out_quiet = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    sb = new();
    n_sent = 0;
    in_quiet = 1'b0;
    rst_ni = 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty heap, key and payload extremes, equal keys.
    send_item(make_extract());
    send_item(make_insert(32'sh7fff_ffff, 32'hffff_ffff));
    send_item(make_insert(32'sh8000_0000, 32'h0000_0000));
    send_item(make_insert('0, 32'ha5a5_a5a5));
    send_item(make_insert(-1, 32'h5a5a_5a5a));
    send_item(make_insert(5, 32'h0000_0001));
    send_item(make_insert(5, 32'h0000_0002));
    send_item(make_insert(5, 32'h0000_0003));
    repeat (8) send_item(make_extract());
    send_item(make_insert(7, 32'h8000_0000));
    send_item(make_extract());
    send_item(make_extract());

    // Random traffic, then a fill past full and a drain past empty.
    run_mixed(250, 60);
    while (sb.fill < DEPTH) send_random_item(100);
    repeat (5) send_random_item(100);
    run_mixed(20, 50);
    while (sb.fill > 0) send_item(make_extract());
    repeat (3) send_item(make_extract());
    run_mixed(150, 55);
    run_mixed(100, 40);

    in_valid_i <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d inserts (%0d dropped on full heap), %0d extracts (%0d on empty heap)",
             sb.n_insert, sb.n_dropped, sb.n_extract, sb.n_on_empty);
    $display("Checked %0d results in %0d cycles", sb.n_checked, cycles);
    if (sb.errors == 0) begin
      $display("** min_heap_priority_queue_unit: PASSED **");
    end else begin
      $display("** min_heap_priority_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule
